>>> rtl/core/dmx_light_effect_generator_macros.svh
// assertion helpers for the core module
`ifndef DMX_LIGHT_EFFECT_GENERATOR_MACROS_SVH
`define DMX_LIGHT_EFFECT_GENERATOR_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define DMX_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define DMX_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dmx_leg_pkg.sv
package dmx_leg_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int LVL_W        = 8;
    localparam int FRAME_W      = 64;
    localparam int MODE_W       = 2;
    localparam int CHAN_W       = 3;
    localparam int LEVEL_W      = 16;
    localparam int EFF_W        = 3;
    localparam int PHASE_W      = 9;

    // command codes
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_ONE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WR_ALL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SELECT = 2'd3;

    // effect codes
    localparam logic [EFF_W-1:0] EFF_STATIC  = 3'd0;
    localparam logic [EFF_W-1:0] EFF_BREATH  = 3'd1;
    localparam logic [EFF_W-1:0] EFF_RAINBOW = 3'd2;
    localparam logic [EFF_W-1:0] EFF_CHASE   = 3'd3;
    localparam logic [EFF_W-1:0] EFF_WAVE    = 3'd4;

    localparam logic [PHASE_W-1:0] DEG_FULL = 9'd360;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;

    typedef logic [LVL_W-1:0] deg_rom_t [360];
    typedef logic [LVL_W-1:0] brth_rom_t [256];

    // floor(127.5 +/- 127.5*sin(x)), x in q30 on the first quarter wave
    function automatic logic [LVL_W-1:0] lvl_from_x(input longint x, input bit peak,
                                                    input bit neg);
        longint x2;
        longint term;
        longint s;
        longint total;
        if (peak) begin
            s = ONE_Q30;
        end
        else begin
            s    = x;
            x2   = (x * x) >>> 30;
            term = x;
            // alternating taylor terms, divisors (2n)(2n+1) for n = 1..8
            term = ((term * x2) >>> 30) / 6;
            s    = s - term;
            term = ((term * x2) >>> 30) / 20;
            s    = s + term;
            term = ((term * x2) >>> 30) / 42;
            s    = s - term;
            term = ((term * x2) >>> 30) / 72;
            s    = s + term;
            term = ((term * x2) >>> 30) / 110;
            s    = s - term;
            term = ((term * x2) >>> 30) / 156;
            s    = s + term;
            term = ((term * x2) >>> 30) / 210;
            s    = s - term;
            term = ((term * x2) >>> 30) / 272;
            s    = s + term;
        end
        total = 255 * ONE_Q30 + (neg ? -255 * s : 255 * s);
        if (total < 0) begin
            total = 0;
        end
        total = total >>> 31;
        if (total > 255) begin
            total = 255;
        end
        return LVL_W'(total);
    endfunction

    // level per whole degree
    function automatic deg_rom_t build_deg_rom();
        deg_rom_t rom;
        longint   q;
        bit       neg;
        for (int p = 0; p < 360; p++) begin
            q   = longint'(p);
            neg = 1'b0;
            if (q >= 180) begin
                neg = 1'b1;
                q   = q - 180;
            end
            if (q > 90) begin
                q = 180 - q;
            end
            rom[p] = lvl_from_x((PI_Q30 * q) / 180, q == 90, neg);
        end
        return rom;
    endfunction

    // breathing level, indexed by half the step (step is always even)
    function automatic brth_rom_t build_brth_rom();
        brth_rom_t rom;
        longint    q;
        bit        neg;
        for (int k = 0; k < 256; k++) begin
            q   = longint'(2 * k);
            neg = 1'b0;
            if (q >= 256) begin
                neg = 1'b1;
                q   = q - 256;
            end
            if (q > 128) begin
                q = 256 - q;
            end
            rom[k] = lvl_from_x((PI_Q30 * q) / 256, q == 128, neg);
        end
        return rom;
    endfunction

    localparam deg_rom_t  SINE_DEG_ROM  = build_deg_rom();
    localparam brth_rom_t SINE_BRTH_ROM = build_brth_rom();

    // power-up level of a channel
    function automatic logic [LVL_W-1:0] reset_level(input int idx);
        return (idx >= 7) ? 8'd255 : LVL_W'((idx + 1) * 32);
    endfunction

    // chase level from distance behind the head
    function automatic logic [LVL_W-1:0] chase_level(input int behind);
        return (behind < 2) ? 8'd255 : ((behind < 4) ? 8'd100 : 8'd0);
    endfunction

endpackage

>>> rtl/core/dmx_leg_if.sv
interface dmx_leg_cmd_if;
    import dmx_leg_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [CHAN_W-1:0]         channel;
    logic signed [LEVEL_W-1:0] level;
    logic [EFF_W-1:0]          effect;

    modport source (output valid, mode, channel, level, effect, input ready);
    modport sink   (input valid, mode, channel, level, effect, output ready);
endinterface

interface dmx_leg_res_if;
    import dmx_leg_pkg::*;

    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame;
    logic [EFF_W-1:0]   active_effect;

    modport source (output valid, frame, active_effect, input ready);
    modport sink   (input valid, frame, active_effect, output ready);
endinterface

>>> rtl/core/dmx_light_effect_generator.sv
// a writing or ticking item sweeps the issue and modify stages, then the done state
//   registers any due frame onto res; no new item is taken before it is through; the single
//   read port of the level memory visits one channel per cycle, plus any wait on res.ready
// selects, ticks with nothing running and writes past the last channel end in idle, with no sweep
// reset: async active low; levels come back to 32,64,..,224,255 through per-entry
//   valid flags, no clearing pass; effect static, animation stopped, auto send on
`include "dmx_light_effect_generator_macros.svh"

module dmx_light_effect_generator #(
    parameter int CHANNELS = dmx_leg_pkg::CHANNELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    dmx_leg_cmd_if.sink         cmd,
    dmx_leg_res_if.source       res
);
    import dmx_leg_pkg::*;

    localparam int IDX_W = $clog2(CHANNELS);
    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int POS_W = $clog2(2 * CHANNELS);
    localparam int DW    = $clog2(2 * CHANNELS + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                proc_valid_reg;
    logic [IDX_W-1:0]    proc_idx_reg;
    logic                changed_reg, changed_next;
    logic                act_reg, act_next;
    logic [EFF_W-1:0]    effect_reg, effect_next;
    logic                running_reg, running_next;
    logic                auto_send_reg, auto_send_next;
    logic [PHASE_W-1:0]  breath_reg, breath_next;
    logic [PHASE_W-1:0]  rainbow_reg, rainbow_next;
    logic [PHASE_W-1:0]  wave_reg, wave_next;
    logic [POS_W-1:0]    chase_reg, chase_next;
    logic [CHANNELS-1:0] valid_reg;
    logic                rd_hit_reg;
    logic                res_valid_reg, res_valid_next;

    // item and datapath registers
    logic [MODE_W-1:0]         op_reg;
    logic [CHAN_W-1:0]         ch_reg;
    logic signed [LEVEL_W-1:0] lv_reg;
    logic [LVL_W-1:0]          clamp_reg;
    logic [EFF_W-1:0]          tick_eff_reg;
    logic [PHASE_W-1:0]        angle_reg;
    logic [IDX_W-1:0]          dist_reg;
    logic [LVL_W-1:0]          gen_val_reg;
    logic [LVL_W-1:0]          mem_rd_reg;
    logic [FRAME_W-1:0]        frame_reg;
    logic [FRAME_W-1:0]        res_frame_reg;
    logic [EFF_W-1:0]          res_effect_reg;

    // channel level memory, one read and one write port
    logic [LVL_W-1:0] lvl_mem [CHANNELS];

    logic               accept;
    logic               start;
    logic               issue_en;
    logic [IDX_W-1:0]   rd_idx;
    logic               emit;
    logic               out_free;
    logic               res_load;
    logic [LVL_W-1:0]   clamp_in;
    logic [LVL_W-1:0]   old_lvl;
    logic [LVL_W-1:0]   new_lvl;
    logic [PHASE_W-1:0] breath_inc;
    logic [PHASE_W:0]   rainbow_sum;
    logic [PHASE_W-1:0] rainbow_inc;
    logic [PHASE_W:0]   wave_sum;
    logic [PHASE_W-1:0] wave_inc;
    logic [POS_W:0]     chase_sum;
    logic [POS_W-1:0]   chase_inc;
    logic [DW-1:0]      dist_t0;
    logic [DW-1:0]      dist_t1;
    logic [DW-1:0]      dist_t2;
    logic [PHASE_W:0]   angle_sum;
    logic [PHASE_W-1:0] angle_wrap;
    logic               sweep_end;
    logic               phase_ok;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign rd_idx    = rd_cnt_reg[IDX_W-1:0];
    assign issue_en  = (state_reg == ST_SWEEP) && (rd_cnt_reg != CNT_W'(CHANNELS));
    assign out_free  = !res_valid_reg || res.ready;

    assign res.valid         = res_valid_reg;
    assign res.frame         = res_frame_reg;
    assign res.active_effect = res_effect_reg;

    // clamp the requested level to a byte
    always_comb
    begin
        if (cmd.level < 16'sd0)
        begin
            clamp_in = '0;
        end
        else if (cmd.level > 16'sd255)
        begin
            clamp_in = 8'd255;
        end
        else
        begin
            clamp_in = cmd.level[LVL_W-1:0];
        end
    end

    // phase counters advanced by one tick
    always_comb
    begin
        breath_inc  = breath_reg + 9'd2;
        rainbow_sum = {1'b0, rainbow_reg} + 10'd4;
        rainbow_inc = (rainbow_sum >= {1'b0, DEG_FULL}) ?
                      PHASE_W'(rainbow_sum - {1'b0, DEG_FULL}) : rainbow_sum[PHASE_W-1:0];
        wave_sum    = {1'b0, wave_reg} + 10'd3;
        wave_inc    = (wave_sum >= {1'b0, DEG_FULL}) ?
                      PHASE_W'(wave_sum - {1'b0, DEG_FULL}) : wave_sum[PHASE_W-1:0];
        chase_sum   = {1'b0, chase_reg} + (POS_W + 1)'(1);
        chase_inc   = (chase_sum == (POS_W + 1)'(2 * CHANNELS)) ? '0 : chase_sum[POS_W-1:0];
        // distance of channel 0 behind the chase head, true modulo
        dist_t0     = DW'(2 * CHANNELS) - DW'(chase_inc);
        dist_t1     = (dist_t0 >= DW'(CHANNELS)) ? dist_t0 - DW'(CHANNELS) : dist_t0;
        dist_t2     = (dist_t1 >= DW'(CHANNELS)) ? dist_t1 - DW'(CHANNELS) : dist_t1;
    end

    // per-channel angle step for rainbow and wave
    always_comb
    begin
        angle_sum  = {1'b0, angle_reg} + ((tick_eff_reg == EFF_RAINBOW) ? 10'd45 : 10'd30);
        angle_wrap = (angle_sum >= {1'b0, DEG_FULL}) ?
                     PHASE_W'(angle_sum - {1'b0, DEG_FULL}) : angle_sum[PHASE_W-1:0];
    end

    // modify stage: stored level against the new one
    always_comb
    begin
        old_lvl = rd_hit_reg ? mem_rd_reg : reset_level(int'(proc_idx_reg));
        case (op_reg)
            MODE_WR_ONE: new_lvl = (proc_idx_reg == ch_reg[IDX_W-1:0]) ? clamp_reg : old_lvl;
            MODE_WR_ALL: new_lvl = clamp_reg;
            default:     new_lvl = gen_val_reg;
        endcase
    end

    // write-all always emits, write-one if unclamped level != stored byte, tick only on change
    assign emit = (op_reg == MODE_WR_ALL) || ((op_reg == MODE_WR_ONE) && act_reg) ||
                  ((op_reg == MODE_TICK) && changed_reg);

    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        changed_next   = changed_reg;
        act_next       = act_reg;
        effect_next    = effect_reg;
        running_next   = running_reg;
        auto_send_next = auto_send_reg;
        breath_next    = breath_reg;
        rainbow_next   = rainbow_reg;
        wave_next      = wave_reg;
        chase_next     = chase_reg;
        start          = 1'b0;
        res_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.mode)
                        MODE_SELECT:
                        begin
                            if ((cmd.effect <= EFF_WAVE) && (cmd.effect != effect_reg))
                            begin
                                effect_next = cmd.effect;
                                if (cmd.effect == EFF_STATIC)
                                begin
                                    running_next = 1'b0;
                                end
                                else if (auto_send_reg)
                                begin
                                    running_next = 1'b1;
                                end
                            end
                        end
                        MODE_WR_ONE:
                        begin
                            // channel numbers past the last one are dropped
                            start = (int'(cmd.channel) < CHANNELS);
                        end
                        MODE_WR_ALL:
                        begin
                            start = 1'b1;
                        end
                        default:
                        begin
                            if (running_reg && (effect_reg != EFF_STATIC))
                            begin
                                start = 1'b1;
                                case (effect_reg)
                                    EFF_BREATH:  breath_next  = breath_inc;
                                    EFF_RAINBOW: rainbow_next = rainbow_inc;
                                    EFF_CHASE:   chase_next   = chase_inc;
                                    default:     wave_next    = wave_inc;
                                endcase
                            end
                        end
                    endcase
                end
                if (start)
                begin
                    state_next   = ST_SWEEP;
                    rd_cnt_next  = '0;
                    changed_next = 1'b0;
                    act_next     = 1'b0;
                end
            end
            ST_SWEEP:
            begin
                if (issue_en)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (proc_valid_reg)
                begin
                    if (new_lvl != old_lvl)
                    begin
                        changed_next = 1'b1;
                    end
                    // unclamped level against the stored byte
                    if ((op_reg == MODE_WR_ONE) && (proc_idx_reg == ch_reg[IDX_W-1:0]))
                    begin
                        act_next = (lv_reg != {8'h00, old_lvl});
                    end
                    if (proc_idx_reg == IDX_W'(CHANNELS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!emit)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (op_reg != MODE_TICK)
                    begin
                        running_next = 1'b0;
                        effect_next  = EFF_STATIC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // config must arrive only while idle; the block itself does not enforce it
        if (cfg_wr_en && (cfg_wr_data != auto_send_reg))
        begin
            auto_send_next = cfg_wr_data;
            if (cfg_wr_data && (effect_reg != EFF_STATIC))
            begin
                running_next = 1'b1;
            end
        end

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_cnt_reg     <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            changed_reg    <= 1'b0;
            act_reg        <= 1'b0;
            effect_reg     <= EFF_STATIC;
            running_reg    <= 1'b0;
            auto_send_reg  <= 1'b1;
            breath_reg     <= '0;
            rainbow_reg    <= '0;
            wave_reg       <= '0;
            chase_reg      <= '0;
            valid_reg      <= '0;
            rd_hit_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            proc_valid_reg <= issue_en;
            proc_idx_reg   <= rd_idx;
            changed_reg    <= changed_next;
            act_reg        <= act_next;
            effect_reg     <= effect_next;
            running_reg    <= running_next;
            auto_send_reg  <= auto_send_next;
            breath_reg     <= breath_next;
            rainbow_reg    <= rainbow_next;
            wave_reg       <= wave_next;
            chase_reg      <= chase_next;
            res_valid_reg  <= res_valid_next;
            if (issue_en)
            begin
                rd_hit_reg <= valid_reg[rd_idx];
            end
            if (proc_valid_reg)
            begin
                valid_reg[proc_idx_reg] <= 1'b1;
            end
        end
    end

    // level memory: read in the issue stage, written back in the modify stage
    always_ff @(posedge clk)
    begin
        if (proc_valid_reg)
        begin
            lvl_mem[proc_idx_reg] <= new_lvl;
        end
        if (issue_en)
        begin
            mem_rd_reg <= lvl_mem[rd_idx];
        end
    end

    // pattern generator, registered alongside the memory read
    always_ff @(posedge clk)
    begin
        if (issue_en)
        begin
            case (tick_eff_reg)
                EFF_BREATH: gen_val_reg <= SINE_BRTH_ROM[breath_reg[PHASE_W-1:1]];
                EFF_CHASE:  gen_val_reg <= chase_level(int'(dist_reg));
                default:    gen_val_reg <= SINE_DEG_ROM[angle_reg];
            endcase
        end
    end

    // item capture and per-channel walkers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg       <= cmd.mode;
            ch_reg       <= cmd.channel;
            lv_reg       <= cmd.level;
            clamp_reg    <= clamp_in;
            tick_eff_reg <= effect_reg;
            angle_reg    <= (effect_reg == EFF_RAINBOW) ? rainbow_inc : wave_inc;
            dist_reg     <= dist_t2[IDX_W-1:0];
            frame_reg    <= '0;
        end
        else
        begin
            if (issue_en)
            begin
                angle_reg <= angle_wrap;
                dist_reg  <= (dist_reg == IDX_W'(CHANNELS - 1)) ? '0 : dist_reg + IDX_W'(1);
            end
            if (proc_valid_reg)
            begin
                frame_reg[{proc_idx_reg, 3'b000} +: LVL_W] <= new_lvl;
            end
        end
        if (res_load)
        begin
            res_frame_reg  <= frame_reg;
            res_effect_reg <= (op_reg == MODE_TICK) ? tick_eff_reg : EFF_STATIC;
        end
    end

    assign sweep_end = (rd_cnt_reg == CNT_W'(CHANNELS));
    assign phase_ok  = (rainbow_reg < DEG_FULL) && (wave_reg < DEG_FULL) &&
                       (int'(chase_reg) < 2 * CHANNELS);

    // no read-modify-write in flight once back in idle
    `DMX_ASSERT_IMPLY(a_idle_no_wb, state_reg == ST_IDLE, !proc_valid_reg, "write-back in idle")
    // every channel has been issued before a frame is decided
    `DMX_ASSERT_IMPLY(a_done_swept, state_reg == ST_DONE, sweep_end, "sweep incomplete")
    // animation never runs in static mode
    `DMX_ASSERT_IMPLY(a_run_effect, running_reg, effect_reg != EFF_STATIC, "running while static")
    // phase counters stay in range
    `DMX_ASSERT_ALWAYS(a_phase_rng, phase_ok, "phase out of range")

endmodule

>>> sim/dmx_light_effect_generator_tb.sv
`default_nettype none

module dmx_light_effect_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmx_leg_pkg::*;

    // run shape
    localparam int NUM_CH        = CHANNELS_DEF;
    localparam int SETTLE_CYCLES = 2 * (NUM_CH + 3);
    localparam int LIMIT_CYCLES  = 600000;
    localparam int RANDOM_ITEMS  = 950;
    localparam int RANDOM_PHASES = 5;

    // q30 constants for the sine levels
    localparam longint Q30_UNIT = 64'sd1073741824;
    localparam longint Q30_PI   = 64'sd3373259426;

    // one expected frame
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [EFF_W-1:0]   effect;
    } frame_rec_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    dmx_leg_cmd_if cmd_ch ();
    dmx_leg_res_if frame_ch ();

    dmx_light_effect_generator #(
        .CHANNELS (NUM_CH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_ch),
        .res         (frame_ch)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predicted state of the light controller
    // ------------------------------------------------------------------
    logic [LVL_W-1:0] chan_level [NUM_CH];
    logic [EFF_W-1:0] eff_now;
    bit               anim_on;
    bit               auto_start;
    int unsigned      breath_step;
    int unsigned      rainbow_deg;
    int unsigned      wave_deg;
    int unsigned      chase_pos;

    // sine levels per breathing step and per whole degree
    logic [LVL_W-1:0] breath_lut [512];
    logic [LVL_W-1:0] deg_lut    [360];

    frame_rec_t frames_due [$];

    int  mismatches;
    int  cycle_count;
    bit  cmd_held;     // valid is being held high from the last item
    bit  no_gaps;      // stretch with no idling on either side
    int  ready_stall;

    // floor(127.5 + 127.5*sin(2*pi*pos/period)) in q30 fixed point
    function automatic logic [LVL_W-1:0] sine_to_level(input int unsigned pos,
                                                       input int unsigned period);
        int unsigned half;
        int unsigned quarter;
        bit          lower;
        longint      s;
        longint      x;
        longint      x2;
        longint      term;
        longint      total;
        half    = period / 2;
        quarter = period / 4;
        lower   = 1'b0;
        pos     = pos % period;
        if (pos >= half)
        begin
            lower = 1'b1;
            pos   = pos - half;
        end
        if (pos > quarter)
            pos = half - pos;
        if (pos == quarter)
        begin
            s = Q30_UNIT;
        end
        else
        begin
            // taylor series on the first quarter wave
            x    = (Q30_PI * longint'(pos)) / longint'(2 * quarter);
            x2   = (x * x) >>> 30;
            term = x;
            s    = x;
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * x2) >>> 30) / longint'(2 * n * (2 * n + 1));
                if (n % 2 == 1)
                    s = s - term;
                else
                    s = s + term;
            end
        end
        total = 255 * Q30_UNIT + (lower ? -255 * s : 255 * s);
        if (total < 0)
            total = 0;
        total = total >>> 31;
        if (total > 255)
            total = 255;
        return LVL_W'(total);
    endfunction

    function automatic logic [LVL_W-1:0] clamp_level(input logic signed [LEVEL_W-1:0] req);
        if (req < 0)
            return '0;
        if (req > 255)
            return 8'd255;
        return LVL_W'(req);
    endfunction

    function automatic void queue_frame();
        frame_rec_t rec;
        rec.frame = '0;
        for (int i = 0; i < NUM_CH; i++)
            rec.frame[8 * i +: 8] = chan_level[i];
        rec.effect = eff_now;
        frames_due.push_back(rec);
    endfunction

    // power-up state
    function automatic void reset_model();
        for (int i = 0; i < NUM_CH; i++)
            chan_level[i] = ((i + 1) * 32 > 255) ? 8'd255 : LVL_W'((i + 1) * 32);
        eff_now     = EFF_STATIC;
        anim_on     = 1'b0;
        auto_start  = 1'b1;
        breath_step = 0;
        rainbow_deg = 0;
        wave_deg    = 0;
        chase_pos   = 0;
        for (int k = 0; k < 512; k++)
            breath_lut[k] = sine_to_level(k, 512);
        for (int k = 0; k < 360; k++)
            deg_lut[k] = sine_to_level(k, 360);
    endfunction

    // auto start register; turning it on starts a selected moving effect
    function automatic void apply_auto_start(input bit val);
        if (val != auto_start)
        begin
            auto_start = val;
            if (val && eff_now != EFF_STATIC)
                anim_on = 1'b1;
        end
    endfunction

    // next state for one accepted item
    function automatic void apply_item(input logic [MODE_W-1:0] md,
                                       input logic [CHAN_W-1:0] ch,
                                       input logic signed [LEVEL_W-1:0] req,
                                       input logic [EFF_W-1:0] eff);
        logic [LVL_W-1:0] next_lvl [NUM_CH];
        bit               changed;
        int unsigned      behind;
        changed = 1'b0;
        case (md)
            MODE_WR_ONE:
            begin
                // the unclamped level is compared, so out of range always acts
                if (int'(ch) >= NUM_CH || int'(chan_level[ch]) == int'(req))
                    return;
                anim_on        = 1'b0;
                eff_now        = EFF_STATIC;
                chan_level[ch] = clamp_level(req);
                queue_frame();
            end
            MODE_WR_ALL:
            begin
                anim_on = 1'b0;
                eff_now = EFF_STATIC;
                for (int i = 0; i < NUM_CH; i++)
                    chan_level[i] = clamp_level(req);
                queue_frame();
            end
            MODE_SELECT:
            begin
                if (eff > EFF_WAVE || eff == eff_now)
                    return;
                eff_now = eff;
                if (eff == EFF_STATIC)
                    anim_on = 1'b0;
                else if (auto_start)
                    anim_on = 1'b1;
            end
            default:
            begin
                if (!anim_on || eff_now == EFF_STATIC || eff_now > EFF_WAVE)
                    return;
                case (eff_now)
                    EFF_BREATH:
                    begin
                        breath_step = (breath_step + 2) % 512;
                        for (int i = 0; i < NUM_CH; i++)
                            next_lvl[i] = breath_lut[breath_step];
                    end
                    EFF_RAINBOW:
                    begin
                        rainbow_deg = (rainbow_deg + 4) % 360;
                        for (int i = 0; i < NUM_CH; i++)
                            next_lvl[i] = deg_lut[(rainbow_deg + 45 * i) % 360];
                    end
                    EFF_CHASE:
                    begin
                        chase_pos = (chase_pos + 1) % (2 * NUM_CH);
                        for (int i = 0; i < NUM_CH; i++)
                        begin
                            // true modulo distance behind the head
                            behind = (i + 2 * NUM_CH - chase_pos) % NUM_CH;
                            next_lvl[i] = (behind < 2) ? 8'd255 :
                                          ((behind < 4) ? 8'd100 : 8'd0);
                        end
                    end
                    default:
                    begin
                        wave_deg = (wave_deg + 3) % 360;
                        for (int i = 0; i < NUM_CH; i++)
                            next_lvl[i] = deg_lut[(wave_deg + 30 * i) % 360];
                    end
                endcase
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (chan_level[i] != next_lvl[i])
                    begin
                        chan_level[i] = next_lvl[i];
                        changed       = 1'b1;
                    end
                end
                // a tick that leaves every channel alone sends nothing
                if (changed)
                    queue_frame();
            end
        endcase
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // ------------------------------------------------------------------
    // frame side: random back-pressure and checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (ready_stall > 0)
        begin
            frame_ch.ready <= 1'b0;
            ready_stall = ready_stall - 1;
        end
        else
        begin
            frame_ch.ready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0)
                ready_stall = pick_gap();
        end
    end

    // every accepted frame is matched against the oldest prediction
    always @(posedge clk)
    begin
        frame_rec_t want;
        if (rst_n === 1'b1 && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1)
        begin
            if (frames_due.size() == 0)
            begin
                $error("frame: none expected, got %h effect %0d",
                       frame_ch.frame, frame_ch.active_effect);
                mismatches++;
            end
            else
            begin
                want = frames_due.pop_front();
                if (frame_ch.frame !== want.frame)
                begin
                    $error("frame: expected %h got %h", want.frame, frame_ch.frame);
                    mismatches++;
                end
                if (frame_ch.active_effect !== want.effect)
                begin
                    $error("active_effect: expected %0d got %0d",
                           want.effect, frame_ch.active_effect);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAIL dmx_light_effect_generator");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    // one command item; valid stays high afterwards so items can go back to back
    task automatic send_item(input logic [MODE_W-1:0] md, input logic [CHAN_W-1:0] ch,
                             input logic signed [LEVEL_W-1:0] req,
                             input logic [EFF_W-1:0] eff);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (cmd_held && gap > 0)
            cmd_ch.valid <= 1'b0;
        // valid was dropped by end_burst, let it be seen low before it rises again
        if (!cmd_held && gap == 0)
            gap = 1;
        repeat (gap) @(posedge clk);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.mode    <= md;
        cmd_ch.channel <= ch;
        cmd_ch.level   <= req;
        cmd_ch.effect  <= eff;
        cmd_held = 1'b1;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        apply_item(md, ch, req, eff);
    endtask

    // drop valid right at the acceptance edge of the last item
    task automatic end_burst();
        if (cmd_held)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_held = 1'b0;
        end
    endtask

    // all frames in, then let a silent tick finish inside the block
    task automatic wait_drained();
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic set_auto_start(input bit val);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        apply_auto_start(val);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // level extremes, clamping and the write-if-different rule
    task automatic test_channel_writes();
        send_item(MODE_WR_ONE, 3'd0, 16'sd32, EFF_STATIC);     // equal to power-up level
        send_item(MODE_WR_ONE, 3'd0, 16'sd0, EFF_STATIC);
        send_item(MODE_WR_ONE, 3'd7, 16'sh7FFF, EFF_STATIC);   // clamps to what is stored
        send_item(MODE_WR_ONE, 3'd3, -16'sd32768, EFF_STATIC);
        send_item(MODE_WR_ONE, 3'd5, 16'sd256, EFF_STATIC);
        send_item(MODE_WR_ONE, 3'd6, -16'sd1, EFF_STATIC);
        send_item(MODE_WR_ALL, 3'd0, 16'sd255, EFF_STATIC);
        send_item(MODE_WR_ALL, 3'd0, -16'sd32768, EFF_STATIC);
        send_item(MODE_WR_ALL, 3'd0, 16'sh7FFF, EFF_STATIC);
        end_burst();
        wait_drained();
    endtask

    // each pattern, repeated and invalid selects, ticks with nothing running
    task automatic test_effect_patterns();
        send_item(MODE_TICK, 3'd0, 16'sd0, EFF_STATIC);
        send_item(MODE_SELECT, 3'd0, 16'sd0, EFF_BREATH);
        send_item(MODE_TICK, 3'd0, 16'sd0, EFF_STATIC);
        send_item(MODE_SELECT, 3'd0, 16'sd0, EFF_BREATH);      // already selected
        send_item(MODE_SELECT, 3'd0, 16'sd0, 3'd7);            // unknown effect codes
        send_item(MODE_SELECT, 3'd0, 16'sd0, 3'd5);
        send_item(MODE_SELECT, 3'd0, 16'sd0, EFF_RAINBOW);
        send_item(MODE_TICK, 3'd0, 16'sd0, EFF_STATIC);
        send_item(MODE_SELECT, 3'd0, 16'sd0, EFF_CHASE);
        send_item(MODE_TICK, 3'd0, 16'sd0, EFF_STATIC);
        send_item(MODE_SELECT, 3'd0, 16'sd0, EFF_WAVE);
        send_item(MODE_TICK, 3'd0, 16'sd0, EFF_STATIC);
        send_item(MODE_SELECT, 3'd0, 16'sd0, EFF_STATIC);
        send_item(MODE_TICK, 3'd0, 16'sd0, EFF_STATIC);
        end_burst();
        wait_drained();
    endtask

    // auto start off: select holds, turning it on starts, turning it off does not stop
    task automatic test_auto_start();
        set_auto_start(1'b0);
        send_item(MODE_SELECT, 3'd0, 16'sd0, EFF_CHASE);
        send_item(MODE_TICK, 3'd0, 16'sd0, EFF_STATIC);
        end_burst();
        wait_drained();
        set_auto_start(1'b1);
        send_item(MODE_TICK, 3'd0, 16'sd0, EFF_STATIC);
        end_burst();
        wait_drained();
        set_auto_start(1'b0);
        send_item(MODE_TICK, 3'd0, 16'sd0, EFF_STATIC);
        send_item(MODE_WR_ONE, 3'd2, 16'sd77, EFF_STATIC);
        end_burst();
        wait_drained();
        set_auto_start(1'b1);                                   // static, nothing starts
        send_item(MODE_TICK, 3'd0, 16'sd0, EFF_STATIC);
        end_burst();
        wait_drained();
    endtask

    // mostly effect runs with ticks, mixed with writes and stray selects
    task automatic test_random_traffic();
        int                        done;
        int                        r;
        logic [CHAN_W-1:0]         ch;
        logic signed [LEVEL_W-1:0] req;
        logic [EFF_W-1:0]          eff;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            // phase boundary: block idle, new auto start setting
            end_burst();
            wait_drained();
            if (ph == 0)
                set_auto_start(1'b0);
            else if (ph == 1)
                set_auto_start(1'b1);
            else
                set_auto_start(1'($urandom_range(0, 1)));
            done = 0;
            while (done < RANDOM_ITEMS / RANDOM_PHASES)
            begin
                if ($urandom_range(0, 49) == 0)
                    no_gaps = !no_gaps;
                // hold off until every frame is back
                if ($urandom_range(0, 99) == 0)
                begin
                    end_burst();
                    wait_drained();
                end
                r   = $urandom_range(0, 99);
                ch  = CHAN_W'($urandom_range(0, NUM_CH - 1));
                req = LEVEL_W'($urandom);
                eff = EFF_STATIC;
                if (r < 58)
                begin
                    send_item(MODE_TICK, ch, req, eff);
                end
                else if (r < 72)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 8)
                        eff = EFF_W'($urandom_range(EFF_BREATH, EFF_WAVE));
                    else if (r == 8)
                        eff = EFF_STATIC;
                    else
                        eff = EFF_W'($urandom_range(EFF_WAVE + 1, 7));
                    send_item(MODE_SELECT, ch, req, eff);
                end
                else if (r < 88)
                begin
                    r = $urandom_range(0, 3);
                    if (r == 0)
                        req = {8'd0, chan_level[ch]};           // same as stored
                    else if (r < 3)
                        req = LEVEL_W'($urandom_range(0, 255));
                    send_item(MODE_WR_ONE, ch, req, eff);
                end
                else
                begin
                    if ($urandom_range(0, 9) < 7)
                        req = LEVEL_W'($urandom_range(0, 255));
                    send_item(MODE_WR_ALL, ch, req, eff);
                end
                done++;
            end
        end
        no_gaps = 1'b0;
        end_burst();
    endtask

    initial
    begin
        // known values on every input from time zero
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.mode    = MODE_TICK;
        cmd_ch.channel = '0;
        cmd_ch.level   = '0;
        cmd_ch.effect  = EFF_STATIC;
        frame_ch.ready = 1'b0;
        mismatches     = 0;
        cycle_count    = 0;
        cmd_held       = 1'b0;
        no_gaps        = 1'b0;
        ready_stall    = 0;
        reset_model();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_channel_writes();
        test_effect_patterns();
        test_auto_start();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0 && frames_due.size() == 0)
            $display("PASS dmx_light_effect_generator");
        else
            $display("FAIL dmx_light_effect_generator");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/dmx_leg_pkg.sv
rtl/core/dmx_leg_if.sv
rtl/core/dmx_light_effect_generator.sv
sim/dmx_light_effect_generator_tb.sv
